// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Overlapping implication: cons holds in the cycle of ante.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rstn, (ante) |-> (cons), msg)

// Non-overlapping implication: cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/slle_pkg.sv =====
// Shared codes and field widths of the linked list engine.
// No dependencies.
`timescale 1ns / 1ps

package slle_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned FIELD_W  = 32;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_INS_BEFORE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_INS_AFTER  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REMOVE     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

endpackage

// ===== hw/rtl/singly_linked_list_engine.sv =====
// Linked list engine: node pool in two synchronous memories, command sequencer.
// Depends on slle_pkg.
//
//   channel   dir  handshake          fields
//   command   in   start & !busy      opcode_i, search_key_i, new_value_i
//   result    out  done_o, one cycle  status_o, list_length_o, head_value_o,
//                                     tail_value_o, list_empty_o
//
// A push goes through S_ALLOC, S_WR1, S_WR2 and S_FIN, with S_AWAIT after S_ALLOC when
// its node comes off the free chain. A keyed insert first walks the list in S_WALK to
// the node with the key, then goes on as a push; a remove goes from S_WALK to S_WR1,
// S_WR2 and S_FIN, a miss from S_WALK to S_FIN. The walk does one read per node.
// Reset clears the list pointers and counters at once; node memories stay
// undefined and need no clearing pass. busy is high from the cycle after acceptance
// through the done_o cycle; results cannot be held off.
`timescale 1ns / 1ps

module singly_linked_list_engine
  import slle_pkg::*;
#(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [FIELD_W-1:0]  search_key_i,
  input  logic [FIELD_W-1:0]  new_value_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [LEN_W-1:0]    list_length_o,
  output logic [FIELD_W-1:0]  head_value_o,
  output logic [FIELD_W-1:0]  tail_value_o,
  output logic                list_empty_o
);

  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned VW = VALUE_WIDTH;
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_AWAIT = 3'd3;
  localparam logic [2:0] S_WR1   = 3'd4;
  localparam logic [2:0] S_WR2   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [VW-1:0] val_mem [CAPACITY];
  logic [IW-1:0] link_mem [CAPACITY];

  logic [2:0]          state_q, state_d;
  logic [OPCODE_W-1:0] op_q, op_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [VW-1:0]       key_q, key_d, val_q, val_d;
  logic [IW-1:0]       first_q, first_d, last_q, last_d, free_q, free_d;
  logic [IW-1:0]       wm_q, wm_d, count_q, count_d;
  logic [IW-1:0]       cur_q, cur_d, prev_q, prev_d, nxt_q, nxt_d, node_q, node_d;
  logic [VW-1:0]       prev_val_q, prev_val_d, head_val_q, head_val_d;
  logic [VW-1:0]       tail_val_q, tail_val_d;

  logic [VW-1:0] rd_val_q;
  logic [IW-1:0] rd_link_q;
  logic [IW-1:0] rd_addr;
  logic          val_we, link_we;
  logic [IW-1:0] val_wa, link_wa, link_wd;

  logic [VW+FIELD_W-1:0] key_x, new_x, head_x, tail_x;
  logic [IW+LEN_W-1:0]   len_x;

  assign key_x = {{VW{1'b0}}, search_key_i};
  assign new_x = {{VW{1'b0}}, new_value_i};

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wa[AW-1:0]] <= val_q;
    end
    if (link_we) begin
      link_mem[link_wa[AW-1:0]] <= link_wd;
    end
    rd_val_q  <= val_mem[rd_addr[AW-1:0]];
    rd_link_q <= link_mem[rd_addr[AW-1:0]];
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    status_d   = status_q;
    key_d      = key_q;
    val_d      = val_q;
    first_d    = first_q;
    last_d     = last_q;
    free_d     = free_q;
    wm_d       = wm_q;
    count_d    = count_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    nxt_d      = nxt_q;
    node_d     = node_q;
    prev_val_d = prev_val_q;
    head_val_d = head_val_q;
    tail_val_d = tail_val_q;
    rd_addr    = cur_q;
    val_we     = 1'b0;
    val_wa     = node_q;
    link_we    = 1'b0;
    link_wa    = node_q;
    link_wd    = NIL;

    case (state_q)
      S_IDLE: begin
        rd_addr = first_q;
        if (start) begin
          op_d     = opcode_i;
          key_d    = key_x[VW-1:0];
          val_d    = new_x[VW-1:0];
          status_d = ST_DONE;
          prev_d   = NIL;
          cur_d    = first_q;
          if (opcode_i inside {OP_PUSH_FRONT, OP_PUSH_BACK}) begin
            state_d = S_ALLOC;
          end else if (opcode_i inside {OP_INS_BEFORE, OP_INS_AFTER, OP_REMOVE}) begin
            if (first_q == NIL) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_FIN;
            end else begin
              state_d = S_WALK;
            end
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_WALK: begin
        if (rd_val_q == key_q) begin
          nxt_d   = rd_link_q;
          state_d = (op_q == OP_REMOVE) ? S_WR1 : S_ALLOC;
        end else begin
          prev_d     = cur_q;
          prev_val_d = rd_val_q;
          if (rd_link_q == NIL) begin
            status_d = ST_NOT_FOUND;
            state_d  = S_FIN;
          end else begin
            cur_d   = rd_link_q;
            rd_addr = rd_link_q;
          end
        end
      end
      S_ALLOC: begin
        if (count_q == NIL) begin
          status_d = ST_FULL;
          state_d  = S_FIN;
        end else if (free_q != NIL) begin
          node_d  = free_q;
          rd_addr = free_q;
          state_d = S_AWAIT;
        end else begin
          node_d  = wm_q;
          wm_d    = wm_q + 1'b1;
          state_d = S_WR1;
        end
      end
      S_AWAIT: begin
        free_d  = rd_link_q;
        state_d = S_WR1;
      end
      S_WR1: begin
        state_d = S_WR2;
        case (op_q)
          OP_REMOVE: begin
            link_we = 1'b1;
            link_wa = cur_q;
            link_wd = free_q;
            free_d  = cur_q;
            rd_addr = nxt_q;
          end
          OP_PUSH_FRONT: begin
            val_we  = 1'b1;
            link_we = 1'b1;
            link_wd = first_q;
          end
          OP_PUSH_BACK: begin
            val_we  = 1'b1;
            link_we = 1'b1;
            link_wd = NIL;
          end
          OP_INS_BEFORE: begin
            val_we  = 1'b1;
            link_we = 1'b1;
            link_wd = cur_q;
          end
          default: begin
            val_we  = 1'b1;
            link_we = 1'b1;
            link_wd = nxt_q;
          end
        endcase
      end
      S_WR2: begin
        state_d = S_FIN;
        count_d = count_q + 1'b1;
        case (op_q)
          OP_PUSH_FRONT: begin
            first_d    = node_q;
            head_val_d = val_q;
            if (last_q == NIL) begin
              last_d     = node_q;
              tail_val_d = val_q;
            end
          end
          OP_PUSH_BACK: begin
            if (last_q != NIL) begin
              link_we = 1'b1;
              link_wa = last_q;
              link_wd = node_q;
            end else begin
              first_d    = node_q;
              head_val_d = val_q;
            end
            last_d     = node_q;
            tail_val_d = val_q;
          end
          OP_INS_BEFORE: begin
            if (prev_q != NIL) begin
              link_we = 1'b1;
              link_wa = prev_q;
              link_wd = node_q;
            end else begin
              first_d    = node_q;
              head_val_d = val_q;
            end
          end
          OP_INS_AFTER: begin
            link_we = 1'b1;
            link_wa = cur_q;
            link_wd = node_q;
            if (cur_q == last_q) begin
              last_d     = node_q;
              tail_val_d = val_q;
            end
          end
          default: begin
            count_d = (count_q != '0) ? count_q - 1'b1 : count_q;
            if (prev_q != NIL) begin
              link_we = 1'b1;
              link_wa = prev_q;
              link_wd = nxt_q;
            end else begin
              first_d    = nxt_q;
              head_val_d = rd_val_q;
            end
            if (cur_q == last_q) begin
              last_d     = prev_q;
              tail_val_d = prev_val_q;
            end
            if (prev_q == NIL && nxt_q == NIL) begin
              last_d = NIL;
            end
          end
        endcase
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= NIL;
      last_q  <= NIL;
      free_q  <= NIL;
      wm_q    <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      last_q  <= last_d;
      free_q  <= free_d;
      wm_q    <= wm_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    status_q   <= status_d;
    key_q      <= key_d;
    val_q      <= val_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    nxt_q      <= nxt_d;
    node_q     <= node_d;
    prev_val_q <= prev_val_d;
    head_val_q <= head_val_d;
    tail_val_q <= tail_val_d;
  end

  assign head_x = {{FIELD_W{1'b0}}, head_val_q};
  assign tail_x = {{FIELD_W{1'b0}}, tail_val_q};
  assign len_x  = {{LEN_W{1'b0}}, count_q};

  assign busy          = (state_q != S_IDLE);
  assign done_o        = (state_q == S_FIN);
  assign status_o      = status_q;
  assign list_length_o = len_x[LEN_W-1:0];
  assign list_empty_o  = (first_q == NIL);
  assign head_value_o  = (first_q == NIL) ? '0 : head_x[FIELD_W-1:0];
  assign tail_value_o  = (last_q == NIL) ? '0 : tail_x[FIELD_W-1:0];

endmodule

// ===== hw/rtl/slle_checker.sv =====
// Port-level checks on the linked list engine, bound into singly_linked_list_engine.
// Depends on slle_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slle_checker
  import slle_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input logic [LEN_W-1:0]    list_length_o,
  input logic [FIELD_W-1:0]  head_value_o,
  input logic [FIELD_W-1:0]  tail_value_o,
  input logic                list_empty_o
);

  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "item accepted without busy")
  `ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o, "result strobe longer than one cycle")
  `ASSERT_IMPL(a_done_busy, clk_i, rst_ni, done_o, busy, "result shown while idle")
  `ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, done_o && list_empty_o, list_length_o == '0 && head_value_o == '0 && tail_value_o == '0, "empty list with nonzero length or values")

endmodule

bind singly_linked_list_engine slle_checker u_slle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .list_length_o (list_length_o),
  .head_value_o  (head_value_o),
  .tail_value_o  (tail_value_o),
  .list_empty_o  (list_empty_o)
);
